// ----- hw/rtl/u2u8_pkg.sv -----
// u2u8_pkg: shared types, constants and a byte-encoding helper for the
// utf-16 to utf-8 encoder; no dependencies
`timescale 1ns / 1ps

package u2u8_pkg;

  localparam int QueueDepth = 2;   // default depth of the front-to-back job queue
  localparam int MaxBytes   = 6;   // most bytes one item can cause
  localparam int ByteCntW   = 3;   // holds 0..MaxBytes

  localparam logic [15:0] HighBase = 16'hD800;
  localparam logic [15:0] LowBase  = 16'hDC00;
  localparam logic [15:0] HighTop  = 16'hDBFF;
  localparam logic [15:0] LowTop   = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // one job: the bytes an item causes, index 0 goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [ByteCntW-1:0]      cnt;
  } job_t;

  function automatic logic [2:0][7:0] enc_three(input logic [15:0] u);
    logic [2:0][7:0] b;
    b[0] = {4'hE, u[15:12]};
    b[1] = {2'b10, u[11:6]};
    b[2] = {2'b10, u[5:0]};
    return b;
  endfunction

endpackage

// ----- hw/rtl/u2u8_front.sv -----
// u2u8_front: accepts code units, tracks a held high surrogate and turns
// each item into a job of up to six bytes; uses u2u8_pkg
`timescale 1ns / 1ps

module u2u8_front import u2u8_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     push,
  output job_t     push_job
);

  logic        held_valid_r, held_valid_nxt;
  logic [15:0] held_high_r, held_high_nxt;

  logic            accept;
  logic            is_high, is_low;
  logic [15:0]     u;
  logic [20:0]     cp;
  logic [3:0][7:0] a_bytes;
  logic [2:0]      a_cnt;
  logic [2:0][7:0] b_bytes;
  logic [2:0]      b_cnt;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign u        = in_data.code_unit;
  assign is_high  = (u >= HighBase) && (u <= HighTop);
  assign is_low   = (u >= LowBase) && (u <= LowTop);
  assign cp       = SuppBase + {1'b0, held_high_r[9:0], u[9:0]};

  always_comb begin
    a_bytes        = '0;
    a_cnt          = 3'd0;
    b_bytes        = '0;
    b_cnt          = 3'd0;
    held_valid_nxt = held_valid_r;
    held_high_nxt  = held_high_r;
    if (is_high) begin
      // flush a previous high surrogate, hold the new one unless string ends
      if (held_valid_r) begin
        a_bytes[2:0] = enc_three(held_high_r);
        a_cnt        = 3'd3;
      end
      if (in_data.end_of_string) begin
        b_bytes        = enc_three(u);
        b_cnt          = 3'd3;
        held_valid_nxt = 1'b0;
      end else begin
        held_valid_nxt = 1'b1;
      end
      held_high_nxt = u;
    end else if (held_valid_r && is_low) begin
      // surrogate pair into a four-byte sequence
      a_bytes[0]     = {5'b11110, cp[20:18]};
      a_bytes[1]     = {2'b10, cp[17:12]};
      a_bytes[2]     = {2'b10, cp[11:6]};
      a_bytes[3]     = {2'b10, cp[5:0]};
      a_cnt          = 3'd4;
      held_valid_nxt = 1'b0;
    end else begin
      if (held_valid_r) begin
        a_bytes[2:0] = enc_three(held_high_r);
        a_cnt        = 3'd3;
      end
      held_valid_nxt = 1'b0;
      if (u[15:7] == 9'd0) begin
        b_bytes[0] = u[7:0];
        b_cnt      = 3'd1;
      end else if (u[15:11] == 5'd0) begin
        b_bytes[0] = {3'b110, u[10:6]};
        b_bytes[1] = {2'b10, u[5:0]};
        b_cnt      = 3'd2;
      end else begin
        b_bytes = enc_three(u);
        b_cnt   = 3'd3;
      end
    end
  end

  // pack the two parts back to back
  always_comb begin
    push_job.bytes = '0;
    case (a_cnt)
      3'd3: begin
        push_job.bytes[2:0] = a_bytes[2:0];
        push_job.bytes[5:3] = b_bytes;
      end
      3'd4: begin
        push_job.bytes[3:0] = a_bytes;
      end
      default: begin
        push_job.bytes[2:0] = b_bytes;
      end
    endcase
    push_job.cnt = a_cnt + b_cnt;
  end

  assign push = accept && (push_job.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (accept) begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_high_r <= held_high_nxt;
    end
  end

endmodule

// ----- hw/rtl/u2u8_queue.sv -----
// u2u8_queue: small job queue between front and back
// uses u2u8_pkg for the job type
`timescale 1ns / 1ps

module u2u8_queue import u2u8_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rd_ptr_r];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/u2u8_back.sv -----
// u2u8_back: walks the head job one byte per cycle, while out_stall is low, into the output register
// uses u2u8_pkg
`timescale 1ns / 1ps

module u2u8_back import u2u8_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                out_valid_r;
  out_item_t           out_data_r, out_data_nxt;
  logic [ByteCntW-1:0] idx_r;
  logic                load, take, is_last;

  assign load    = !out_valid_r || !out_stall;
  assign take    = load && !empty;
  assign is_last = (idx_r == head_job.cnt - 1'b1);
  assign pop     = take && is_last;

  assign out_data_nxt.out_byte  = head_job.bytes[idx_r];
  assign out_data_nxt.last_byte = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) out_valid_r <= !empty;
      if (take) idx_r <= is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/utf16_to_utf8_encoder.sv -----
// utf16_to_utf8_encoder: utf-16 code units in, utf-8 bytes out
// path: an accepted item is written into the queue, then its first byte into the output register
// throughput: one byte per cycle while out_stall is low, set by the single-byte output register;
//   each item gives 0 to 6 bytes, 3 for most bmp text
// reset: rst_n synchronous active low, clears held surrogate, queue and output
// depends on u2u8_pkg, u2u8_front, u2u8_queue, u2u8_back
`timescale 1ns / 1ps

module utf16_to_utf8_encoder import u2u8_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  // code unit side
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // byte side
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // front to queue
  logic push;
  job_t push_job;
  // queue to back
  logic q_full, q_empty, pop;
  job_t head_job;

  // front: classifies the unit, pairs surrogates, builds the byte list
  u2u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // queue lets the front take new units while bytes of earlier ones drain
  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_job (head_job)
  );

  // back: serializes each job, marks its final byte
  u2u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/u2u8_checker.sv -----
// u2u8_checker: port-level assertions for the encoder, bound to the top level
// uses u2u8_pkg for the item types
`timescale 1ns / 1ps

module u2u8_checker import u2u8_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // nothing on the output right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // final byte of an item is never a lead byte
  a_last_not_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_byte |-> out_data.out_byte[7:6] != 2'b11)
    else $error("item ends on a lead byte");

  // bytes of one item come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_byte |=> out_valid)
    else $error("gap inside an item's byte sequence");

  // no byte above the four-byte lead range
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_byte[7:3] != 5'b11111)
    else $error("invalid utf-8 byte");

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_u2u8_checker (.*);
